[design/air_pkg.sv]
// Shared types and constants of the affine image resampler.
// Used by air_ctrl, air_dp and affine_image_resampler.
`default_nettype none
package air_pkg;

	localparam int IMG_W_DEF     = 256;
	localparam int IMG_H_DEF     = 256;
	localparam int FRAC_BITS_DEF = 16;

	localparam int ADDR_W    = 16;
	localparam int PIX_W     = 8;
	localparam int COORD_W   = 12;
	localparam int COEF_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CTL_W     = 10;
	localparam int MODE_W    = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YC  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PIX_CTL  = 3'd7;

	localparam logic signed [COEF_W-1:0] COEF_UNIT_RST = 32'sd65536;
	localparam logic [CTL_W-1:0]         PIX_CTL_RST   = 10'd2;

	localparam logic [MODE_W-1:0] MODE_NEAREST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BILINEAR = 2'd1;

	typedef struct packed {
		logic       load_wr;
		logic       map_start;
		logic       rd;
		logic [3:0] rd_k;
		logic       cr_mul;
		logic       cr_add;
		logic [2:0] cr_row;
		logic [1:0] cr_step;
		logic       bl_row;
		logic       bl_col;
		logic       fin;
	} cmd_t;

	typedef struct packed {
		logic mode_near;
		logic mode_bil;
		logic inb;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[design/affine_image_resampler.sv]
// Top level of the affine image resampler: sequencer plus datapath.
// Depends on air_pkg, air_ctrl and air_dp.
`default_nettype none
// A load item (kind 0) writes one source pixel and is taken at once when idle. A map
// item (kind 1) is worked on alone and holds off the input until its result is
// in the output register. An out-of-bounds sample skips the fetch; otherwise the
// work is set by the single read port of the source memory, which fetches the
// 4x4 window (one pixel for nearest) one pixel per cycle, and, for bicubic, by
// the one shared multiplier that steps through the Catmull-Rom terms, a multiply
// then an add per term, over four rows and the column. The output register
// decouples the two sides; a new item is taken while a result waits.
module affine_image_resampler #(
	parameter int IMG_W     = air_pkg::IMG_W_DEF,
	parameter int IMG_H     = air_pkg::IMG_H_DEF,
	parameter int FRAC_BITS = air_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [air_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [air_pkg::COEF_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          kind,
	input  wire logic [air_pkg::ADDR_W-1:0]    load_addr,
	input  wire logic [air_pkg::PIX_W-1:0]     load_value,
	input  wire logic [air_pkg::COORD_W-1:0]   out_x,
	input  wire logic [air_pkg::COORD_W-1:0]   out_y,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [air_pkg::COORD_W-1:0]        res_x,
	output logic [air_pkg::COORD_W-1:0]        res_y,
	output logic [air_pkg::PIX_W-1:0]          pixel,
	output logic                               written
);

	air_pkg::cmd_t cmd;
	air_pkg::sts_t sts;

	air_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	air_dp #(
		.IMG_W     (IMG_W),
		.IMG_H     (IMG_H),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.load_addr  (load_addr),
		.load_value (load_value),
		.out_x      (out_x),
		.out_y      (out_y),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res_x      (res_x),
		.res_y      (res_y),
		.pixel      (pixel),
		.written    (written)
	);

endmodule
`default_nettype wire

[design/air_ctrl.sv]
// Sequencer of the affine image resampler: walks each item through the
// coordinate pipe, the pixel fetch and the interpolation steps. Uses air_pkg.
`default_nettype none
module air_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          kind,
	input  air_pkg::sts_t      sts,
	output air_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PIPE  = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_DRAIN = 4'd3;
	localparam logic [3:0] S_CRMUL = 4'd4;
	localparam logic [3:0] S_CRADD = 4'd5;
	localparam logic [3:0] S_BLROW = 4'd6;
	localparam logic [3:0] S_BLCOL = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic [3:0] k_q, k_d;
	logic [2:0] row_q, row_d;
	logic [1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			row_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
			row_q   <= row_d;
			step_q  <= step_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		row_d   = row_q;
		step_d  = step_q;
		cmd           = '0;
		cmd.rd_k      = k_q;
		cmd.cr_row    = row_q;
		cmd.cr_step   = step_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_wr   = in_valid && !kind;
				cmd.map_start = in_valid && kind;
				if (in_valid && kind) begin
					state_d = S_PIPE;
					cnt_d   = '0;
				end
			end
			S_PIPE: begin
				// wait for the coordinate and bounds stages to settle
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					k_d     = '0;
					state_d = sts.inb ? S_FETCH : S_FIN;
				end
			end
			S_FETCH: begin
				cmd.rd = 1'b1;
				k_d    = k_q + 4'd1;
				if (sts.mode_near || k_q == 4'd15)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				row_d  = '0;
				step_d = '0;
				if (sts.mode_near)
					state_d = S_FIN;
				else if (sts.mode_bil)
					state_d = S_BLROW;
				else
					state_d = S_CRMUL;
			end
			S_CRMUL: begin
				cmd.cr_mul = 1'b1;
				state_d    = S_CRADD;
			end
			S_CRADD: begin
				cmd.cr_add = 1'b1;
				state_d    = S_CRMUL;
				if (step_q == 2'd2) begin
					step_d = '0;
					row_d  = row_q + 3'd1;
					if (row_q == 3'd4)
						state_d = S_FIN;
				end else begin
					step_d = step_q + 2'd1;
				end
			end
			S_BLROW: begin
				cmd.bl_row = 1'b1;
				state_d    = S_BLCOL;
			end
			S_BLCOL: begin
				cmd.bl_col = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[design/air_dp.sv]
// Datapath of the affine image resampler: registers, coordinate pipe, source
// image memory, interpolation arithmetic and output register. Uses air_pkg.
`default_nettype none
module air_dp #(
	parameter int IMG_W     = air_pkg::IMG_W_DEF,
	parameter int IMG_H     = air_pkg::IMG_H_DEF,
	parameter int FRAC_BITS = air_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [air_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [air_pkg::COEF_W-1:0]       cfg_wdata,
	input  wire logic [air_pkg::ADDR_W-1:0]       load_addr,
	input  wire logic [air_pkg::PIX_W-1:0]        load_value,
	input  wire logic [air_pkg::COORD_W-1:0]      out_x,
	input  wire logic [air_pkg::COORD_W-1:0]      out_y,
	input  air_pkg::cmd_t                         cmd,
	output air_pkg::sts_t                         sts,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [air_pkg::COORD_W-1:0]           res_x,
	output logic [air_pkg::COORD_W-1:0]           res_y,
	output logic [air_pkg::PIX_W-1:0]             pixel,
	output logic                                  written
);

	localparam int F      = FRAC_BITS;
	localparam int AW     = air_pkg::ADDR_W;
	localparam int PW8    = air_pkg::PIX_W;
	localparam int CW     = air_pkg::COORD_W;
	localparam int MW     = air_pkg::COEF_W + CW + 1;
	localparam int TW     = MW + 2;
	localparam int IW     = TW + 2 - F;
	localparam int ACC_W  = F + 18;
	localparam int PRW    = ACC_W + F + 1;
	localparam int BRW    = F + 10;
	localparam int BNW    = 2 * F + 12;
	localparam int VW     = ACC_W - F - 1;
	localparam int DEPTH  = 1 << AW;

	localparam logic signed [TW:0]   HALF_V = 1 <<< (F - 1);
	localparam logic signed [IW-1:0] W_V    = IW'(IMG_W);
	localparam logic signed [IW-1:0] H_V    = IW'(IMG_H);
	localparam logic [AW-1:0]        W16    = AW'(IMG_W);
	localparam logic [F:0]           ONE_V  = (F + 1)'(1) << F;

	// configuration
	logic signed [air_pkg::COEF_W-1:0] cxx_q, cxy_q, cxc_q, cyx_q, cyy_q, cyc_q;
	logic [air_pkg::MODE_W-1:0]        mode_q;
	logic [air_pkg::CTL_W-1:0]         pctl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cxx_q  <= air_pkg::COEF_UNIT_RST;
			cxy_q  <= '0;
			cxc_q  <= '0;
			cyx_q  <= '0;
			cyy_q  <= air_pkg::COEF_UNIT_RST;
			cyc_q  <= '0;
			mode_q <= air_pkg::MODE_NEAREST;
			pctl_q <= air_pkg::PIX_CTL_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				air_pkg::REG_COEF_XX: cxx_q  <= cfg_wdata;
				air_pkg::REG_COEF_XY: cxy_q  <= cfg_wdata;
				air_pkg::REG_COEF_XC: cxc_q  <= cfg_wdata;
				air_pkg::REG_COEF_YX: cyx_q  <= cfg_wdata;
				air_pkg::REG_COEF_YY: cyy_q  <= cfg_wdata;
				air_pkg::REG_COEF_YC: cyc_q  <= cfg_wdata;
				air_pkg::REG_MODE:    mode_q <= cfg_wdata[air_pkg::MODE_W-1:0];
				air_pkg::REG_PIX_CTL: pctl_q <= cfg_wdata[air_pkg::CTL_W-1:0];
				default: ;
			endcase
		end
	end

	logic mode_near, mode_bil;
	assign mode_near = (mode_q == air_pkg::MODE_NEAREST);
	assign mode_bil  = (mode_q == air_pkg::MODE_BILINEAR);

	// coordinate pipe; recomputes every cycle from the held item
	logic [CW-1:0] x_q, y_q;
	always_ff @(posedge clk) begin
		if (cmd.map_start) begin
			x_q <= out_x;
			y_q <= out_y;
		end
	end

	logic signed [MW-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1;
	always_ff @(posedge clk) begin
		pxx_s1 <= cxx_q * $signed({1'b0, x_q});
		pxy_s1 <= cxy_q * $signed({1'b0, y_q});
		pyx_s1 <= cyx_q * $signed({1'b0, x_q});
		pyy_s1 <= cyy_q * $signed({1'b0, y_q});
	end

	logic signed [TW-1:0] tx_s2, ty_s2;
	always_ff @(posedge clk) begin
		tx_s2 <= TW'(pxx_s1) + TW'(pxy_s1) + TW'(cxc_q);
		ty_s2 <= TW'(pyx_s1) + TW'(pyy_s1) + TW'(cyc_q);
	end

	logic signed [TW:0]   ax, ay, nax, nay;
	logic signed [IW-1:0] ixn, iyn;
	always_comb begin
		ax  = (TW + 1)'(tx_s2) + HALF_V;
		ay  = (TW + 1)'(ty_s2) + HALF_V;
		nax = -ax;
		nay = -ay;
		// nearest adds one half, then truncates toward zero
		ixn = ax[TW] ? -IW'(nax >>> F) : IW'(ax >>> F);
		iyn = ay[TW] ? -IW'(nay >>> F) : IW'(ay >>> F);
	end

	logic signed [IW-1:0] ixn_s3, iyn_s3, ixf_s3, iyf_s3;
	logic [F-1:0]         fx_s3, fy_s3;
	logic                 neg_s3;
	always_ff @(posedge clk) begin
		ixn_s3 <= ixn;
		iyn_s3 <= iyn;
		ixf_s3 <= IW'(tx_s2 >>> F);
		iyf_s3 <= IW'(ty_s2 >>> F);
		fx_s3  <= tx_s2[F-1:0];
		fy_s3  <= ty_s2[F-1:0];
		neg_s3 <= tx_s2[TW-1] || ty_s2[TW-1];
	end

	logic                 inb_c;
	logic signed [IW-1:0] ix0, iy0;
	always_comb begin
		if (mode_near) begin
			inb_c = !ixn_s3[IW-1] && !iyn_s3[IW-1] && (ixn_s3 < W_V) && (iyn_s3 < H_V);
			ix0   = ixn_s3;
			iy0   = iyn_s3;
		end else if (mode_bil) begin
			inb_c = !neg_s3 && (ixf_s3 <= W_V - 2) && (iyf_s3 <= H_V - 2);
			ix0   = ixf_s3;
			iy0   = iyf_s3;
		end else begin
			inb_c = !neg_s3 && (ixf_s3 >= 1) && (iyf_s3 >= 1)
				&& (ixf_s3 <= W_V - 3) && (iyf_s3 <= H_V - 3);
			ix0   = ixf_s3 - 1;
			iy0   = iyf_s3 - 1;
		end
	end

	logic          inb_s4;
	logic [AW-1:0] base_s4;
	always_ff @(posedge clk) begin
		inb_s4  <= inb_c;
		base_s4 <= iy0[AW-1:0] * W16 + ix0[AW-1:0];
	end

	// source image
	logic [PW8-1:0] mem [0:DEPTH-1];
	logic [PW8-1:0] mem_q;
	logic [AW-1:0]  rd_addr;
	assign rd_addr = base_s4 + AW'(cmd.rd_k[3:2]) * W16 + AW'(cmd.rd_k[1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load_wr)
			mem[load_addr] <= load_value;
		mem_q <= mem[rd_addr];
	end

	logic rd1_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd1_q <= 1'b0;
		else
			rd1_q <= cmd.rd;
	end

	// pixel window: shift in on fetch, rotate one row after each row pass
	logic [PW8-1:0] pix_q [0:15];
	logic signed [ACC_W-1:0] q_q [0:3];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PRW-1:0]   prod_q;

	logic signed [ACC_W-1:0] p0, p1, p2, p3, dr, h3r, c2r;
	logic signed [ACC_W-1:0] dc, h3c, c2c, aop, base, addend, res;
	logic [F-1:0]            tsel;
	logic                    col;
	always_comb begin
		p0  = ACC_W'($signed({1'b0, pix_q[0]}));
		p1  = ACC_W'($signed({1'b0, pix_q[1]}));
		p2  = ACC_W'($signed({1'b0, pix_q[2]}));
		p3  = ACC_W'($signed({1'b0, pix_q[3]}));
		dr  = p1 - p2;
		h3r = (dr <<< 1) + dr + p3 - p0;
		c2r = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
		dc  = q_q[1] - q_q[2];
		h3c = (dc <<< 1) + dc + q_q[3] - q_q[0];
		c2c = (q_q[0] <<< 1) - ((q_q[1] <<< 2) + q_q[1]) + (q_q[2] <<< 2) - q_q[3];
		col  = cmd.cr_row[2];
		tsel = col ? fy_s3 : fx_s3;
		if (cmd.cr_step == 2'd0)
			aop = col ? h3c : h3r;
		else
			aop = acc_q;
		case (cmd.cr_step)
			2'd0:    base = col ? c2c : (c2r <<< F);
			2'd1:    base = col ? (q_q[2] - q_q[0]) : ((p2 - p0) <<< F);
			default: base = col ? (q_q[1] <<< 1) : (p1 <<< (F + 1));
		endcase
		// the first row step adds the product unscaled
		if (col || cmd.cr_step != 2'd0)
			addend = ACC_W'(prod_q >>> F);
		else
			addend = ACC_W'(prod_q);
		res = base + addend;
	end

	always_ff @(posedge clk) begin
		if (rd1_q) begin
			for (int i = 0; i < 15; i++)
				pix_q[i] <= pix_q[i + 1];
			pix_q[15] <= mem_q;
		end else if (cmd.cr_add && cmd.cr_step == 2'd2 && !col) begin
			for (int i = 0; i < 16; i++)
				pix_q[i] <= pix_q[(i + 4) % 16];
		end
		if (cmd.cr_mul)
			prod_q <= $signed({1'b0, tsel}) * aop;
		if (cmd.cr_add) begin
			acc_q <= res;
			if (cmd.cr_step == 2'd2 && !col) begin
				for (int i = 0; i < 3; i++)
					q_q[i] <= q_q[i + 1];
				q_q[3] <= res;
			end
		end
	end

	// bilinear: rows, then column
	logic [F:0]     wx0, wy0;
	logic [BRW-1:0] r0_q, r1_q;
	logic [BNW-1:0] num_q;
	assign wx0 = ONE_V - {1'b0, fx_s3};
	assign wy0 = ONE_V - {1'b0, fy_s3};

	always_ff @(posedge clk) begin
		if (cmd.bl_row) begin
			r0_q <= wx0 * pix_q[0] + {1'b0, fx_s3} * pix_q[1];
			r1_q <= wx0 * pix_q[4] + {1'b0, fx_s3} * pix_q[5];
		end
		if (cmd.bl_col)
			num_q <= wy0 * r0_q + {1'b0, fy_s3} * r1_q;
	end

	// final value
	logic signed [VW-1:0]    vbic, vsel;
	logic signed [ACC_W-1:0] nacc;
	logic [8:0]              vbil;
	logic                    ok, skip_on;
	logic [PW8-1:0]          skipv, clamped, outv;
	always_comb begin
		skip_on = pctl_q[1];
		skipv   = pctl_q[9:2];
		nacc    = -acc_q;
		vbic    = acc_q[ACC_W-1] ? -VW'(nacc >>> (F + 2)) : VW'(acc_q >>> (F + 2));
		vbil    = num_q[2 * F +: 9];
		if (mode_near) begin
			vsel = VW'($signed({1'b0, pix_q[15]}));
			ok   = inb_s4 && !(skip_on && pix_q[15] == skipv);
		end else if (mode_bil) begin
			vsel = VW'($signed({1'b0, vbil}));
			ok   = inb_s4 && !(skip_on && vbil == 9'd0);
		end else begin
			vsel = vbic;
			ok   = inb_s4 && (vbic != '0);
		end
		if (vsel[VW-1])
			clamped = '0;
		else if (vsel > VW'(255))
			clamped = '1;
		else
			clamped = vsel[PW8-1:0];
		outv = pctl_q[0] ? ~clamped : clamped;
	end

	// output register
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.fin)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	logic [CW-1:0]  res_x_q, res_y_q;
	logic [PW8-1:0] pixel_q;
	logic           written_q;
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			res_x_q   <= x_q;
			res_y_q   <= y_q;
			pixel_q   <= ok ? outv : '0;
			written_q <= ok;
		end
	end

	assign out_valid = out_valid_q;
	assign res_x     = res_x_q;
	assign res_y     = res_y_q;
	assign pixel     = pixel_q;
	assign written   = written_q;

	assign sts.mode_near = mode_near;
	assign sts.mode_bil  = mode_bil;
	assign sts.inb       = inb_s4;
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule
`default_nettype wire
